// ===== rtl/ldtm_pkg.sv =====
// Shared types and constants for the log-density tone mapper.
`default_nettype none
package ldtm_pkg;
  localparam int COUNT_W = 32;
  localparam int COLOR_W = 32;
  localparam int FRAC_W  = 16;
  localparam int EXP_W   = 5;
  localparam int LOG_W   = EXP_W + FRAC_W;
  localparam int MANT_W  = 30;
  localparam int DVD_W   = COLOR_W + FRAC_W;
  localparam int DVS_W   = 32;
  localparam int ALPHA_W = FRAC_W + 1;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_SCAN  = 2'd1;
  localparam logic [1:0] OP_MAP   = 2'd2;

  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] peak;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/ldtm_front.sv =====
// Input side: takes items, tracks the peak hit count, queues map jobs.
`default_nettype none
module ldtm_front (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [127:0]                s_tdata,  // red_sum, green_sum, blue_sum, hit_count
  input  wire  [1:0]                  s_tuser,  // op
  input  wire                         q_full,
  output logic                        push,
  output ldtm_pkg::job_t              push_job
);
  import ldtm_pkg::*;

  logic [COUNT_W-1:0] peak;
  logic               accept;
  logic [COUNT_W-1:0] cnt;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign cnt      = s_tdata[127:96];
  assign push     = accept && (s_tuser == OP_MAP);

  always_comb begin
    push_job.red   = s_tdata[31:0];
    push_job.green = s_tdata[63:32];
    push_job.blue  = s_tdata[95:64];
    push_job.count = cnt;
    push_job.peak  = peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= COUNT_W'(1);
    end else if (accept) begin
      case (s_tuser)
        OP_START: peak <= COUNT_W'(1);
        OP_SCAN:  if (cnt > peak) peak <= cnt;
        default:  ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ldtm_queue.sv =====
// Two-entry job queue between the front and back ends.
`default_nettype none
module ldtm_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  ldtm_pkg::job_t  push_job,
  output logic            full,
  input  wire             pop,
  output logic            valid,
  output ldtm_pkg::job_t  head
);
  import ldtm_pkg::*;

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ldtm_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ldtm_divider (
  input  wire                 clk,
  input  wire                 rst,
  input  ldtm_pkg::div_req_t  req,
  output ldtm_pkg::div_rsp_t  rsp
);
  import ldtm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dq;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] left;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign shifted = {rem, dq[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  always_comb begin
    rsp.busy     = busy;
    rsp.done     = done;
    rsp.quotient = dq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        left <= CNT_W'(DVD_W);
        dq   <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem  <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        dq   <= {dq[DVD_W-2:0], fits};
        left <= left - CNT_W'(1);
        if (left == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ldtm_back.sv =====
// Back end: log of counts, alpha, channel ratios and byte scaling.
`default_nettype none
module ldtm_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  ldtm_pkg::job_t      q_head,
  output logic                pop,
  output ldtm_pkg::div_req_t  div_req,
  input  ldtm_pkg::div_rsp_t  div_rsp,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [23:0]         m_tdata,  // red_out, green_out, blue_out
  output logic [0:0]          m_tuser   // written
);
  import ldtm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_SQ, S_DIVA, S_CH, S_DIVC, S_MUL, S_SCALE
  } state_t;

  localparam int PROD_W = 2 * ALPHA_W;

  state_t              state;
  logic                out_hold;
  job_t                job;
  logic                lsel;
  logic [31:0]         v;
  logic [EXP_W-1:0]    e;
  logic [MANT_W:0]     m;
  logic [FRAC_W-1:0]   frac;
  logic [3:0]          step;
  logic [LOG_W-1:0]    lp;
  logic [ALPHA_W-1:0]  alpha;
  logic [1:0]          ch;
  logic [ALPHA_W-1:0]  ratio;
  logic [PROD_W-1:0]   prod;
  logic [7:0]          red_o, green_o, blue_o;
  logic                written;

  logic [2*MANT_W+1:0] sq;
  logic [MANT_W+1:0]   mn;
  logic [FRAC_W-1:0]   frac_next;
  logic [COLOR_W-1:0]  maxc;
  logic [COLOR_W-1:0]  chv;
  logic [PROD_W+7:0]   p255;
  logic [7:0]          byte_v;

  assign sq        = m * m;
  assign mn        = sq[2*MANT_W+1:MANT_W];
  assign frac_next = {frac[FRAC_W-2:0], mn[MANT_W+1]};

  always_comb begin
    maxc = job.red;
    if (job.green > maxc) maxc = job.green;
    if (job.blue > maxc)  maxc = job.blue;
    case (ch)
      2'd0:    chv = job.red;
      2'd1:    chv = job.green;
      default: chv = job.blue;
    endcase
    p255   = {prod, 8'b0} - {8'b0, prod};
    byte_v = (p255[PROD_W+7:32] > (PROD_W-24)'(FULL_BYTE)) ? FULL_BYTE : p255[39:32];
  end

  assign pop      = (state == S_IDLE) && !out_hold && q_valid;
  assign m_tvalid = out_hold;
  assign m_tdata  = {blue_o, green_o, red_o};
  assign m_tuser  = written;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_hold      <= 1'b0;
      alpha         <= '0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (out_hold && m_tready) out_hold <= 1'b0;
      case (state)
        S_IDLE: if (pop) begin
          job     <= q_head;
          ch      <= 2'd0;
          red_o   <= '0;
          green_o <= '0;
          blue_o  <= '0;
          if (q_head.count == '0) begin
            written  <= 1'b0;
            out_hold <= 1'b1;
          end else begin
            written <= 1'b1;
            if (q_head.peak > COUNT_W'(1)) begin
              v     <= q_head.peak;
              e     <= '1;
              lsel  <= 1'b0;
              state <= S_NORM;
            end else begin
              alpha <= '0;
              state <= S_CH;
            end
          end
        end
        S_NORM: begin
          // shift until the leading one sits at the top
          if (v[31]) begin
            m     <= v[31:1];
            frac  <= '0;
            step  <= '0;
            state <= S_SQ;
          end else begin
            v <= {v[30:0], 1'b0};
            e <= e - EXP_W'(1);
          end
        end
        S_SQ: begin
          frac <= frac_next;
          m    <= mn[MANT_W+1] ? mn[MANT_W+1:1] : mn[MANT_W:0];
          step <= step + 4'd1;
          if (step == 4'(FRAC_W - 1)) begin
            if (!lsel) begin
              lp    <= {e, frac_next};
              v     <= job.count;
              e     <= '1;
              lsel  <= 1'b1;
              state <= S_NORM;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= DVD_W'({e, frac_next, {FRAC_W{1'b0}}});
              div_req.divisor  <= DVS_W'(lp);
              state            <= S_DIVA;
            end
          end
        end
        S_DIVA: if (div_rsp.done) begin
          alpha <= (div_rsp.quotient > DVD_W'(ALPHA_ONE)) ? ALPHA_ONE
                                                          : div_rsp.quotient[ALPHA_W-1:0];
          state <= S_CH;
        end
        S_CH: begin
          if (maxc == '0) begin
            out_hold <= 1'b1;
            state    <= S_IDLE;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= {chv, {FRAC_W{1'b0}}};
            div_req.divisor  <= maxc;
            state            <= S_DIVC;
          end
        end
        S_DIVC: if (div_rsp.done) begin
          ratio <= div_rsp.quotient[ALPHA_W-1:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= alpha * ratio;
          state <= S_SCALE;
        end
        S_SCALE: begin
          case (ch)
            2'd0:    red_o   <= byte_v;
            2'd1:    green_o <= byte_v;
            default: blue_o  <= byte_v;
          endcase
          if (ch == 2'd2) begin
            out_hold <= 1'b1;
            state    <= S_IDLE;
          end else begin
            ch    <= ch + 2'd1;
            state <= S_CH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    alpha <= ALPHA_ONE) else $error("alpha above one");
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !written) |-> (m_tdata == '0)) else $error("unwritten pixel not black");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");
  a_no_pop_hold: assert property (@(posedge clk) disable iff (rst)
    out_hold |-> !pop) else $error("job taken while result pending");
endmodule
`default_nettype wire

// ===== rtl/log_density_tone_map_top.sv =====
// Top level of the log-density tone mapper.
// Start and scan items take effect at acceptance, one per cycle while the queue has room.
// A map item with a peak above one runs normalize and squaring loops and an alpha divide; then
// three ratio divides run if any channel is nonzero. A zero-count map item goes straight to the
// output register. Results leave from a held output register.
// Synchronous reset sets the peak count to one and empties the job queue.
`default_nettype none
module log_density_tone_map_top (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [127:0] s_tdata,  // red_sum, green_sum, blue_sum, hit_count
  input  wire  [1:0]   s_tuser,  // op
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [23:0]  m_tdata,  // red_out, green_out, blue_out
  output logic [0:0]   m_tuser   // written
);
  import ldtm_pkg::*;

  logic     push, q_full, q_valid, pop;
  job_t     push_job, q_head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  ldtm_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_full, .push, .push_job
  );

  ldtm_queue u_queue (
    .clk, .rst, .push, .push_job, .full(q_full), .pop, .valid(q_valid), .head(q_head)
  );

  ldtm_divider u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

  ldtm_back u_back (
    .clk, .rst, .q_valid, .q_head, .pop, .div_req, .div_rsp,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );
endmodule
`default_nettype wire

// ===== tb/log_density_tone_map_top_tb.sv =====
// Testbench for the log-density tone mapper: random frames checked against a tone-map predictor.
`default_nettype none
module log_density_tone_map_top_tb;
  import ldtm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD = 4000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] count;
  } pixel_t;

  typedef struct {
    logic       written;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [127:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [23:0] m_tdata;
  logic [0:0] m_tuser;

  pixel_t pixel_queue[$];
  color_t color_queue[$];
  pixel_t cur_pixel;
  logic [31:0] peak_count;
  int errors;
  int cycles;
  int send_gap;
  int recv_gap;
  int hold_left;
  bit idling;
  bit stall_req;
  bit stall_done;
  int pushed;

  log_density_tone_map_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Base-2 log in Q16: leading-one index, then fraction bits by repeated squaring.
  function automatic logic [20:0] log2_q16(input logic [31:0] v);
    int e;
    logic [63:0] m;
    logic [15:0] frac;
    e = 0;
    for (int k = 0; k < 32; k++) if (v[k]) e = k;
    m = 64'(v);
    if (e >= 30) m = m >> (e - 30);
    else m = m << (30 - e);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= (64'd2 << 30)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {e[4:0], frac};
  endfunction

  function automatic logic [7:0] shade(input logic [31:0] ch, input logic [31:0] maxc,
                                       input logic [63:0] alpha);
    logic [63:0] ratio;
    logic [63:0] p;
    ratio = (64'(ch) << 16) / 64'(maxc);
    p = (alpha * ratio * 64'd255) >> 32;
    return (p > 64'd255) ? 8'hFF : p[7:0];
  endfunction

  task automatic tone_map(input pixel_t px);
    color_t c;
    logic [63:0] alpha;
    logic [31:0] maxc;
    c = '{1'b0, 8'd0, 8'd0, 8'd0};
    alpha = 0;
    case (px.op)
      OP_START: peak_count = 32'd1;
      OP_SCAN: if (px.count > peak_count) peak_count = px.count;
      OP_MAP: begin
        if (px.count != 0) begin
          c.written = 1'b1;
          if (peak_count > 1) begin
            alpha = (64'(log2_q16(px.count)) << 16) / 64'(log2_q16(peak_count));
            if (alpha > 64'd65536) alpha = 64'd65536;
          end
          maxc = px.red;
          if (px.green > maxc) maxc = px.green;
          if (px.blue > maxc) maxc = px.blue;
          if (maxc != 0) begin
            c.red = shade(px.red, maxc, alpha);
            c.green = shade(px.green, maxc, alpha);
            c.blue = shade(px.blue, maxc, alpha);
          end
        end
        color_queue.push_back(c);
      end
      default: ;
    endcase
  endtask

  // Sender: one item per handshake, random gap drawn per item while idling.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) tone_map(cur_pixel);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          cur_pixel = pixel_queue.pop_front();
          s_tdata <= {cur_pixel.count, cur_pixel.blue, cur_pixel.green, cur_pixel.red};
          s_tuser <= cur_pixel.op;
          s_tvalid <= 1'b1;
          send_gap <= idling ? $urandom_range(0, 7) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest expectation.
  always @(posedge clk) begin
    color_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      stall_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (color_queue.size() == 0) begin
          $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = color_queue.pop_front();
          if (m_tuser[0] !== want.written) begin
            $display("%0t: written expected %b actual %b", $time, want.written, m_tuser[0]);
            errors++;
          end
          if (m_tdata[7:0] !== want.red) begin
            $display("%0t: red expected %h actual %h", $time, want.red, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[15:8] !== want.green) begin
            $display("%0t: green expected %h actual %h", $time, want.green, m_tdata[15:8]);
            errors++;
          end
          if (m_tdata[23:16] !== want.blue) begin
            $display("%0t: blue expected %h actual %h", $time, want.blue, m_tdata[23:16]);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (stall_req && !stall_done) begin
        hold_left <= LONG_HOLD;
        stall_done <= 1'b1;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready && idling) begin
        recv_gap <= $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push(input logic [1:0] op, input logic [31:0] r, input logic [31:0] g,
                      input logic [31:0] b, input logic [31:0] n);
    pixel_t px;
    px = '{op, r, g, b, n};
    pixel_queue.push_back(px);
    pushed++;
  endtask

  function automatic logic [31:0] rand_color();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return $urandom;
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  // Well-formed frame: start, scan every pixel, then map the same pixels.
  task automatic frame(input int n);
    pixel_t px[$];
    pixel_t p;
    push(OP_START, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++) begin
      p = '{OP_SCAN, rand_color(), rand_color(), rand_color(), rand_count()};
      if ($urandom_range(0, 7) == 0) begin
        p.green = p.red;
        p.blue = p.red;
      end
      px.push_back(p);
      push(OP_SCAN, p.red, p.green, p.blue, p.count);
    end
    foreach (px[i]) push(OP_MAP, px[i].red, px[i].green, px[i].blue, px[i].count);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    while (pixel_queue.size() > 0 || s_tvalid || color_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    pushed = 0;
    idling = 1'b0;
    stall_req = 1'b0;
    peak_count = 32'd1;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: peak of one, zero count, zero channels, count above peak, unused op.
    push(OP_MAP, 32'd100, 32'd50, 32'd0, 32'd7);
    push(OP_MAP, 32'd100, 32'd50, 32'd0, 32'd0);
    push(OP_SCAN, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF);
    push(OP_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(OP_MAP, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd2);
    push(OP_MAP, 32'd0, 32'd0, 32'd0, 32'h1234_5678);
    push(OP_MAP, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'd1);
    push(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(OP_SCAN, 32'd0, 32'd0, 32'd0, 32'd16);
    push(OP_MAP, 32'd7, 32'd5, 32'd3, 32'd16);
    push(OP_MAP, 32'd7, 32'd5, 32'd3, 32'd1000);
    push(OP_MAP, 32'd7, 32'd5, 32'd3, 32'd3);
    push(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(OP_MAP, 32'd1, 32'd1, 32'd1, 32'd16);
    push(OP_SCAN, 32'd0, 32'd0, 32'd0, 32'd2);
    push(OP_MAP, 32'd200, 32'd100, 32'd255, 32'd2);
    drain();

    // Long receiver hold while maps keep arriving, so the input backs up.
    idling = 1'b1;
    stall_req = 1'b1;
    push(OP_START, 32'd0, 32'd0, 32'd0, 32'd0);
    push(OP_SCAN, 32'd0, 32'd0, 32'd0, 32'd4000);
    for (int i = 0; i < 24; i++) push(OP_MAP, $urandom, $urandom, $urandom, rand_count());
    drain();

    while (pushed < 850) begin
      idling = ($urandom_range(0, 3) != 0);
      for (int f = 0; f < 6; f++) begin
        if ($urandom_range(0, 9) == 0) begin
          for (int i = 0; i < 6; i++)
            push(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, rand_count());
        end else begin
          frame($urandom_range(1, 10));
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && color_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
